>>> design/cls_pkg.sv
// Shared types and codes for the circular list store.
package cls_pkg;

	localparam int DATA_W = 32;

	// Operation codes on the request channel
	localparam logic [1:0] FUNC_INSERT   = 2'd0;
	localparam logic [1:0] FUNC_DELETE   = 2'd1;
	localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

	// Status codes on the response channel
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	// Ring commands, the same for every cell in a cycle
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_ROTATE = 2'd2;
	localparam logic [1:0] CMD_DROP   = 2'd3;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [1:0] op;
		data_t      fill;
	} cmd_t;

endpackage

>>> design/cls_req_if.sv
// Request channel: operation code and operand value.
interface cls_req_if;
	import cls_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] func;
	data_t      value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

>>> design/cls_rsp_if.sv
// Response channel: value, status and last-word marker.
interface cls_rsp_if;
	import cls_pkg::*;

	logic       valid;
	logic       ready;
	data_t      out_value;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_value, output status, output last, input ready);
	modport sink (input valid, input out_value, input status, input last, output ready);
endinterface

>>> design/cls_cell.sv
// One list cell: holds one entry and takes its neighbour's entry on command.
module cls_cell (
	input  logic           clk,
	input  cls_pkg::cmd_t  cmd,
	input  logic           is_tail,
	input  cls_pkg::data_t prev_data,
	input  cls_pkg::data_t next_data,
	input  cls_pkg::data_t head_data,
	output cls_pkg::data_t data
);
	import cls_pkg::*;

	data_t data_q;

	// Move the entry one place along the ring, or hold it
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INSERT: data_q <= prev_data;
			CMD_ROTATE: data_q <= is_tail ? head_data : next_data;
			CMD_DROP:   data_q <= next_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

>>> design/cls_chain.sv
// Row of list cells, head at cell 0, wired as a ring of the current length.
module cls_chain #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  cls_pkg::cmd_t    cmd,
	input  logic [CNT_W-1:0] len,
	output cls_pkg::data_t   head
);
	import cls_pkg::*;

	data_t cell_data [CAPACITY];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			data_t prev_d;
			data_t next_d;
			logic  tail;

			// Cell 0 takes the inserted word; the last cell has no right neighbour
			if (gi == 0) begin : g_first
				assign prev_d = cmd.fill;
			end else begin : g_mid
				assign prev_d = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign next_d = cell_data[gi];
			end else begin : g_inner
				assign next_d = cell_data[gi+1];
			end
			assign tail = (len == CNT_W'(gi + 1));

			cls_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.is_tail   (tail),
				.prev_data (prev_d),
				.next_data (next_d),
				.head_data (cell_data[0]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	assign head = cell_data[0];

endmodule

>>> design/circular_list_store_top.sv
// Circular list store: ordered list in a ring of cells with a sequencer.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | func[1:0], value[31:0] signed
//  rsp     | out | valid / ready | out_value[31:0] signed, status[1:0], last
//
// Insert, and delete or traverse of an empty list, give one word;
// unused codes give no word. Delete and traverse of n entries rotate the
// ring one cell per cycle past the head unless the response stalls, and
// after n steps it is back in order (delete drops the first match).
// Reset clears the count and sequencer; cell contents are not cleared.
// A stalled response freezes the ring and holds req.ready low.
module circular_list_store_top #(
	parameter int CAPACITY = 16
) (
	input logic      clk,
	input logic      arst_n,
	cls_req_if.sink  req,
	cls_rsp_if.source rsp
);
	import cls_pkg::*;

	localparam int               CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TRAV = 2'd1;
	localparam logic [1:0] S_DEL  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] rem_q;
	logic             found_q;
	data_t            value_q;
	logic             out_valid_q;
	data_t            out_value_q;
	logic [1:0]       status_q;
	logic             last_q;

	logic             out_free;
	logic             acc;
	logic             step;
	logic             last_step;
	logic             head_match;
	data_t            head;
	cmd_t             cmd;
	logic             load_out;
	data_t            out_value_d;
	logic [1:0]       status_d;
	logic             last_d;

	// Handshake and step enables
	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE) && out_free;
	assign acc        = req.valid && req.ready;
	assign step       = (state_q != S_IDLE) && out_free;
	assign last_step  = (rem_q == ONE_C);
	assign head_match = !found_q && (head == value_q);

	// Drive the ring
	always_comb begin
		cmd.op   = CMD_HOLD;
		cmd.fill = req.value;
		if (acc && req.func == FUNC_INSERT && count_q != CAP_C) begin
			cmd.op = CMD_INSERT;
		end else if (step) begin
			if (state_q == S_DEL && head_match) begin
				cmd.op = CMD_DROP;
			end else begin
				cmd.op = CMD_ROTATE;
			end
		end
	end

	cls_chain #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.len  (len_q),
		.head (head)
	);

	// Choose the response word
	always_comb begin
		load_out    = 1'b0;
		out_value_d = req.value;
		status_d    = STAT_OK;
		last_d      = 1'b1;
		if (acc) begin
			unique case (req.func)
				FUNC_INSERT: begin
					load_out = 1'b1;
					status_d = (count_q == CAP_C) ? STAT_FULL : STAT_OK;
				end
				FUNC_DELETE: begin
					load_out = (count_q == '0);
					status_d = STAT_NOT_FOUND;
				end
				FUNC_TRAVERSE: begin
					load_out    = (count_q == '0);
					out_value_d = '0;
					status_d    = STAT_EMPTY;
				end
				default: load_out = 1'b0;
			endcase
		end else if (step) begin
			if (state_q == S_TRAV) begin
				load_out    = 1'b1;
				out_value_d = head;
				last_d      = last_step;
			end else begin
				load_out    = last_step;
				out_value_d = value_q;
				status_d    = (found_q || head_match) ? STAT_OK : STAT_NOT_FOUND;
			end
		end
	end

	// Sequencer and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			len_q       <= '0;
			rem_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (acc) begin
				len_q   <= count_q;
				rem_q   <= count_q;
				found_q <= 1'b0;
				if (req.func == FUNC_INSERT && count_q != CAP_C) begin
					count_q <= count_q + ONE_C;
				end
				if (count_q != '0 && req.func == FUNC_DELETE) begin
					state_q <= S_DEL;
				end else if (count_q != '0 && req.func == FUNC_TRAVERSE) begin
					state_q <= S_TRAV;
				end
			end else if (step) begin
				rem_q <= rem_q - ONE_C;
				if (state_q == S_DEL && head_match) begin
					found_q <= 1'b1;
					len_q   <= len_q - ONE_C;
				end
				if (last_step) begin
					state_q <= S_IDLE;
					if (state_q == S_DEL) begin
						count_q <= head_match ? len_q - ONE_C : len_q;
					end
				end
			end
		end
	end

	// Operand and response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			value_q <= req.value;
		end
		if (load_out) begin
			out_value_q <= out_value_d;
			status_q    <= status_d;
			last_q      <= last_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_value = out_value_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count beyond capacity");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready)
		else $error("request taken while a scan runs");

	a_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> rem_q != '0)
		else $error("scan running with no steps left");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.func == FUNC_INSERT && count_q != CAP_C |=>
		count_q == $past(count_q) + ONE_C)
		else $error("insert did not grow the list");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == S_DEL && last_step |=>
		(count_q == $past(count_q) || count_q == $past(count_q) - ONE_C))
		else $error("delete changed the count by more than one");

endmodule
